/* sv/bms_pkg.sv */
// ---------------------------------------------------------------------------
// bms_pkg: shared types and helpers for the merge sorter
// Sizes of the key chain and the order map for double keys.
// ---------------------------------------------------------------------------
`default_nettype none

package bms_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned KeyW     = 64;

  localparam logic [KeyW-1:0] SignBit = {1'b1, {(KeyW-1){1'b0}}};

  typedef logic [KeyW-1:0] key_t;

  // Per-cycle command shared by every cell of the chain.
  typedef struct packed {
    logic ins;  // insert the broadcast key
    logic drn;  // shift one step toward the output
  } cell_ctl_t;

  // Map a double's bits onto unsigned order; -0.0 folds onto +0.0.
  function automatic key_t order_code(input key_t bits);
    key_t b;
    b = (bits == SignBit) ? '0 : bits;
    if (b[KeyW-1]) begin
      return ~b;
    end
    return b | SignBit;
  endfunction

endpackage

`default_nettype wire

/* sv/bms_cell.sv */
// ---------------------------------------------------------------------------
// bms_cell: one slot of the sorting chain
// Holds one key; takes the new key, its left neighbor's key or its right
// neighbor's key, so the chain stays in stable ascending order.
// ---------------------------------------------------------------------------
`default_nettype none

module bms_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bms_pkg::cell_ctl_t ctl_i,
  input  wire bms_pkg::key_t     key_i,
  input  wire logic              prev_lt_i,
  input  wire bms_pkg::key_t     prev_key_i,
  input  wire logic              prev_vld_i,
  input  wire bms_pkg::key_t     next_key_i,
  input  wire logic              next_vld_i,
  output logic                   lt_o,
  output bms_pkg::key_t          key_o,
  output logic                   vld_o
);
  import bms_pkg::*;

  key_t key_q, key_d;
  logic vld_q, vld_d;

  // Strict compare: an equal newcomer goes behind the stored key.
  assign lt_o = !vld_q || (order_code(key_i) < order_code(key_q));

  always_comb begin
    key_d = key_q;
    vld_d = vld_q;
    if (ctl_i.drn) begin
      key_d = next_key_i;
      vld_d = next_vld_i;
    end else if (ctl_i.ins && lt_o) begin
      // open a gap: take the left key if the insertion point lies further left
      key_d = prev_lt_i ? prev_key_i : key_i;
      vld_d = prev_lt_i ? prev_vld_i : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
  assign vld_o = vld_q;

endmodule

`default_nettype wire

/* sv/bottom_up_merge_sorter.sv */
// ---------------------------------------------------------------------------
// bottom_up_merge_sorter: stable ascending sorter for double keys
// Keys enter a chain of cells kept in sorted order; after the last key the
// chain shifts its contents out, smallest first.
// ---------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  request  | key_i, last_i                           | start & !busy
//  result   | sorted_key_o, final_res_o, dropped_o    | result_valid_o
//
//  Load: one key per cycle while not busy; it lands in its sorted slot in that same cycle.
//  Drain: starts the cycle after the last key and gives one result per cycle
//  from the head cell; busy is high throughout.
//  Keys beyond 64 are discarded and flag every result of that set.
//  Reset empties the chain at once; the receiver cannot stall.
// ---------------------------------------------------------------------------
`default_nettype none

module bottom_up_merge_sorter (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire bms_pkg::key_t key_i,
  input  wire logic          last_i,
  output logic               result_valid_o,
  output bms_pkg::key_t      sorted_key_o,
  output logic               final_res_o,
  output logic               dropped_o
);
  import bms_pkg::*;

  key_t                cell_key [MaxItems];
  logic [MaxItems-1:0] cell_vld;
  logic [MaxItems-1:0] cell_lt;
  cell_ctl_t           ctl;

  logic drain_q, drain_d;
  logic ovf_q, ovf_d;
  logic accept, full, fin;

  assign accept = start && !drain_q;
  assign full   = cell_vld[MaxItems-1];
  assign fin    = drain_q && !cell_vld[1];

  assign ctl.ins = accept && !full;
  assign ctl.drn = drain_q;

  for (genvar i = 0; i < MaxItems; i++) begin : g_cell
    logic prev_lt, prev_vld, next_vld;
    key_t prev_key, next_key;

    if (i == 0) begin : g_head
      assign prev_lt  = 1'b0;
      assign prev_key = key_i;
      assign prev_vld = 1'b0;
    end else begin : g_body
      assign prev_lt  = cell_lt[i-1];
      assign prev_key = cell_key[i-1];
      assign prev_vld = cell_vld[i-1];
    end

    if (i == MaxItems - 1) begin : g_tail
      assign next_key = key_i;
      assign next_vld = 1'b0;
    end else begin : g_mid
      assign next_key = cell_key[i+1];
      assign next_vld = cell_vld[i+1];
    end

    bms_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .key_i      (key_i),
      .prev_lt_i  (prev_lt),
      .prev_key_i (prev_key),
      .prev_vld_i (prev_vld),
      .next_key_i (next_key),
      .next_vld_i (next_vld),
      .lt_o       (cell_lt[i]),
      .key_o      (cell_key[i]),
      .vld_o      (cell_vld[i])
    );
  end

  always_comb begin
    drain_d = drain_q;
    ovf_d   = ovf_q;
    if (fin) begin
      drain_d = 1'b0;
      ovf_d   = 1'b0;
    end else if (accept) begin
      if (full) begin
        ovf_d = 1'b1;
      end
      if (last_i) begin
        drain_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      drain_q <= drain_d;
      ovf_q   <= ovf_d;
    end
  end

  assign busy           = drain_q;
  assign result_valid_o = drain_q;
  assign sorted_key_o   = cell_key[0];
  assign final_res_o    = fin;
  assign dropped_o      = ovf_q;

  // Occupied cells always form a contiguous run from the head.
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_vld + {{(MaxItems-1){1'b0}}, 1'b1}) & cell_vld) == '0)
    else $error("chain occupancy has a hole");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> cell_vld[0])
    else $error("result strobed from an empty head cell");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !final_res_o) |->
      !(order_code(cell_key[1]) < order_code(cell_key[0])))
    else $error("drained keys out of order");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_i) |=> result_valid_o)
    else $error("last key did not start the drain");

  a_final_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && final_res_o) |=> (!busy && cell_vld == '0))
    else $error("chain not empty after final result");

endmodule

`default_nettype wire
